@@ hw/rtl/upi_pkg.sv @@
// Shared types and constants for the unicycle pose integrator.
// Holds the opcodes, reset values, the sine/cosine result bundle and the
// arctangent table used by the rotator. No dependencies.
package upi_pkg;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 24;
  localparam int RATE_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int STEP_W   = 16;
  localparam int TRIG_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Input word kinds, carried on s_tuser.
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_VEL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REL  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_ABS  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

  localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd1049;
  localparam logic [POS_W-1:0]  CANVAS_RST    = 24'd728178;
  localparam logic [POS_W-1:0]  CENTRE_RST    = 24'd364089;
  localparam logic [15:0]       TIMEOUT_RST   = 16'd63;

  // Start value of the rotator, unit gain pre-divided, Q2.30.
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

  typedef struct packed {
    logic                     valid;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } sincos_t;

  // Arctangent of 2^-i, with 2^32 units to a full turn.
  function automatic logic signed [TRIG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/upi_sincos.sv @@
// Iterative CORDIC rotator giving cosine and sine of a binary angle, Q2.30.
// One shift-add rotation per cycle. Depends on upi_pkg.
module upi_sincos #(
  parameter int ITERATIONS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [upi_pkg::ANGLE_W-1:0]      angle,
  output upi_pkg::sincos_t                 res
);

  localparam int ITER_W = $clog2(ITERATIONS);
  localparam logic [ITER_W-1:0] LAST = ITER_W'(ITERATIONS - 1);

  logic signed [upi_pkg::TRIG_W-1:0] x, y, z;
  logic signed [upi_pkg::TRIG_W-1:0] x_next, y_next, z_next;
  logic signed [upi_pkg::TRIG_W-1:0] atan_v;
  logic [ITER_W-1:0]                 cnt;
  logic                              busy;
  logic                              flip;
  logic                              valid;
  logic                              fold;
  logic [upi_pkg::ANGLE_W-1:0]       angle_adj;

  // Angles beyond a quarter turn are folded by half a turn and the result negated.
  always_comb begin
    fold = ($signed(angle) > 16'sd16384) || ($signed(angle) < -16'sd16384);
    angle_adj = fold ? (angle + 16'h8000) : angle;
  end

  always_comb begin
    atan_v = upi_pkg::atan_entry(5'(cnt));
    if (!z[upi_pkg::TRIG_W-1]) begin
      x_next = x - (y >>> cnt);
      y_next = y + (x >>> cnt);
      z_next = z - atan_v;
    end else begin
      x_next = x + (y >>> cnt);
      y_next = y - (x >>> cnt);
      z_next = z + atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
      flip  <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
      cnt   <= '0;
      flip  <= fold;
      x     <= upi_pkg::CORDIC_GAIN;
      y     <= '0;
      z     <= {angle_adj, 16'h0000};
    end else if (busy) begin
      z <= z_next;
      if (cnt == LAST) begin
        busy  <= 1'b0;
        valid <= 1'b1;
        x     <= flip ? -x_next : x_next;
        y     <= flip ? -y_next : y_next;
      end else begin
        cnt <= cnt + 1'b1;
        x   <= x_next;
        y   <= y_next;
      end
    end
  end

  assign res.valid = valid;
  assign res.cos_v = x;
  assign res.sin_v = y;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("rotator restarted while busy");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      busy && !start && cnt != LAST |=> busy && cnt == $past(cnt) + 1'b1)
    else $error("rotation counter skipped");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(valid && busy))
    else $error("result flagged valid during rotation");
`endif

endmodule

@@ hw/rtl/unicycle_pose_integrator.sv @@
// Tick: turn and linear rates are multiplied by the step time, the CORDIC rotator runs,
// then cosine and sine are scaled by the distance to move x, then y. Relative teleport
// starts at the rotation; velocity and absolute teleport go straight to the result word.
// One input word is worked on at a time; the next is taken while a result still waits.
// Synchronous reset puts the pose at the canvas centre, heading and rates at zero.
// Depends on upi_pkg and upi_sincos.
module unicycle_pose_integrator #(
  parameter int SINCOS_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // linear_value[23:0], angular_rate[47:24], heading_value[63:48],
  // target_x[87:64], target_y[111:88]
  input  logic [111:0]                        s_tdata,
  // opcode[1:0]
  input  logic [upi_pkg::OPCODE_W-1:0]        s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pose_x[23:0], pose_y[47:24], heading[63:48], linear_speed[87:64],
  // turn_rate[111:88], hit_wall[112], changed[113], draw_segment[114],
  // from_x[138:115], from_y[162:139], zero fill [167:163]
  output logic [167:0]                        m_tdata,
  // Configuration writes.
  input  logic                                cfg_wr_en,
  input  logic [upi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [upi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_MUL_ANG   = 9'b000000010,
    S_MUL_LIN   = 9'b000000100,
    S_ROT_START = 9'b000001000,
    S_ROT_WAIT  = 9'b000010000,
    S_MUL_C     = 9'b000100000,
    S_MUL_S     = 9'b001000000,
    S_POS_Y     = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state;

  // Configuration.
  logic [15:0] step_time;
  logic [23:0] canvas_w;
  logic [23:0] canvas_h;
  logic        pen_enable;
  logic [15:0] timeout;

  // Pose and rate state.
  logic [23:0]        pos_x, pos_y;
  logic [15:0]        head;
  logic signed [23:0] lin_rate, ang_rate;
  logic [15:0]        idle_ticks;

  // Per-word working registers.
  logic [1:0]         op_reg;
  logic [23:0]        from_x, from_y;
  logic [15:0]        from_head;
  logic               hit;
  logic signed [24:0] travel;
  logic signed [56:0] prod;

  // Input fields.
  logic [1:0]         in_op;
  logic signed [23:0] in_lin, in_ang;
  logic [15:0]        in_hv;
  logic [23:0]        in_tx, in_ty;

  logic               accept;
  logic [15:0]        idle_inc;
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [56:0] mul_p;
  logic signed [56:0] prod_r16, prod_r30;
  logic [26:0]        delta;
  logic [27:0]        sum_x, sum_y;
  logic [23:0]        clamp_x, clamp_y;
  logic               hit_x, hit_y;
  logic               out_free;
  logic               moved, changed, draw;
  logic [23:0]        out_pose_y;
  upi_pkg::sincos_t   sc;

  assign in_op  = s_tuser;
  assign in_lin = s_tdata[23:0];
  assign in_ang = s_tdata[47:24];
  assign in_hv  = s_tdata[63:48];
  assign in_tx  = s_tdata[87:64];
  assign in_ty  = s_tdata[111:88];

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  upi_sincos #(.ITERATIONS(SINCOS_ITERATIONS)) u_sincos (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ROT_START),
    .angle (head),
    .res   (sc)
  );

  // The one multiplier: rate by step, then cosine and sine by distance.
  always_comb begin
    case (state)
      S_MUL_ANG: begin
        mul_a = {{8{ang_rate[23]}}, ang_rate};
        mul_b = {9'b0, step_time};
      end
      S_MUL_LIN: begin
        mul_a = {{8{lin_rate[23]}}, lin_rate};
        mul_b = {9'b0, step_time};
      end
      S_MUL_C: begin
        mul_a = sc.cos_v;
        mul_b = travel;
      end
      S_MUL_S: begin
        mul_a = sc.sin_v;
        mul_b = travel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_r16 = (prod + 57'sd32768) >>> 16;
  assign prod_r30 = (prod + 57'sd536870912) >>> 30;
  assign delta    = prod_r30[26:0];
  assign sum_x    = {4'b0000, pos_x} + {delta[26], delta};
  assign sum_y    = {4'b0000, pos_y} - {delta[26], delta};

  // Saturate to the canvas; either bound counts as a wall hit.
  always_comb begin
    hit_x = 1'b1;
    if (sum_x[27]) begin
      clamp_x = '0;
    end else if (sum_x[26:0] > {3'b000, canvas_w}) begin
      clamp_x = canvas_w;
    end else begin
      clamp_x = sum_x[23:0];
      hit_x   = 1'b0;
    end
    hit_y = 1'b1;
    if (sum_y[27]) begin
      clamp_y = '0;
    end else if (sum_y[26:0] > {3'b000, canvas_h}) begin
      clamp_y = canvas_h;
    end else begin
      clamp_y = sum_y[23:0];
      hit_y   = 1'b0;
    end
  end

  always_comb begin
    moved      = (pos_x != from_x) || (pos_y != from_y);
    out_pose_y = (canvas_h >= pos_y) ? canvas_h - pos_y : '0;
    case (op_reg)
      upi_pkg::OP_TICK: begin
        changed = moved || (head != from_head);
        draw    = moved && pen_enable;
      end
      upi_pkg::OP_VEL: begin
        changed = 1'b0;
        draw    = 1'b0;
      end
      default: begin
        changed = 1'b1;
        draw    = pen_enable;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= upi_pkg::STEP_TIME_RST;
      canvas_w      <= upi_pkg::CANVAS_RST;
      canvas_h      <= upi_pkg::CANVAS_RST;
      pen_enable    <= 1'b1;
      timeout       <= upi_pkg::TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        upi_pkg::REG_STEP_TIME: step_time     <= cfg_data[15:0];
        upi_pkg::REG_CANVAS_W:  canvas_w      <= cfg_data;
        upi_pkg::REG_CANVAS_H:  canvas_h      <= cfg_data;
        upi_pkg::REG_PEN_EN:    pen_enable    <= cfg_data[0];
        upi_pkg::REG_TIMEOUT:   timeout       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos_x      <= upi_pkg::CENTRE_RST;
      pos_y      <= upi_pkg::CENTRE_RST;
      head       <= '0;
      lin_rate   <= '0;
      ang_rate   <= '0;
      idle_ticks <= '0;
      m_tvalid   <= 1'b0;
      op_reg     <= upi_pkg::OP_TICK;
      hit        <= 1'b0;
    end else begin
      // In the completion step the valid flag is set there instead.
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_reg    <= in_op;
            from_x    <= pos_x;
            from_y    <= pos_y;
            from_head <= head;
            hit       <= 1'b0;
            case (in_op)
              upi_pkg::OP_TICK: begin
                idle_ticks <= idle_inc;
                if (idle_inc > timeout) begin
                  lin_rate <= '0;
                  ang_rate <= '0;
                end
                state <= S_MUL_ANG;
              end
              upi_pkg::OP_VEL: begin
                lin_rate   <= in_lin;
                ang_rate   <= in_ang;
                idle_ticks <= '0;
                state      <= S_DONE;
              end
              upi_pkg::OP_REL: begin
                head   <= head + in_hv;
                travel <= {in_lin[23], in_lin};
                state  <= S_ROT_START;
              end
              default: begin
                if (in_tx > canvas_w) begin
                  pos_x <= canvas_w;
                  hit   <= 1'b1;
                end else begin
                  pos_x <= in_tx;
                end
                pos_y <= (canvas_h >= in_ty) ? canvas_h - in_ty : '0;
                head  <= in_hv;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL_ANG: begin
          prod  <= mul_p;
          state <= S_MUL_LIN;
        end
        S_MUL_LIN: begin
          head  <= head + prod_r16[15:0];
          prod  <= mul_p;
          state <= S_ROT_START;
        end
        S_ROT_START: begin
          if (op_reg == upi_pkg::OP_TICK) begin
            travel <= prod_r16[24:0];
          end
          state <= S_ROT_WAIT;
        end
        S_ROT_WAIT: begin
          if (sc.valid) begin
            state <= S_MUL_C;
          end
        end
        S_MUL_C: begin
          prod  <= mul_p;
          state <= S_MUL_S;
        end
        S_MUL_S: begin
          pos_x <= clamp_x;
          hit   <= hit | hit_x;
          prod  <= mul_p;
          state <= S_POS_Y;
        end
        S_POS_Y: begin
          pos_y <= clamp_y;
          hit   <= hit | hit_y;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b00000, from_y, from_x, draw, changed, hit,
                         ang_rate, lin_rate, head, out_pose_y, pos_x};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_x_bounded: assert property (@(posedge clk) disable iff (rst)
      state == S_DONE && op_reg != upi_pkg::OP_VEL |-> pos_x <= canvas_w)
    else $error("x left the canvas after a move");
  a_vel_clean: assert property (@(posedge clk) disable iff (rst)
      state == S_DONE && op_reg == upi_pkg::OP_VEL |-> idle_ticks == '0 && !hit)
    else $error("velocity word left idle count or wall flag set");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result word raised outside the completion step");
`endif

endmodule

@@ verif/pose_checker.sv @@
// Checker for the unicycle pose integrator: follows register writes and input words,
// predicts the result word of each one and compares it with what the block sends.
// Depends on upi_pkg for widths, opcodes, register indexes and reset values.
module pose_checker #(
  parameter int SINCOS_ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [111:0]                   s_tdata,
  input  logic [upi_pkg::OPCODE_W-1:0]   s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [167:0]                   m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [upi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             outstanding,
  output int                             mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_FRAC = 16;
  localparam int TRIG_FRAC = 30;

  typedef struct packed {
    logic [upi_pkg::POS_W-1:0]          pose_x;
    logic [upi_pkg::POS_W-1:0]          pose_y;
    logic signed [upi_pkg::ANGLE_W-1:0] heading;
    logic signed [upi_pkg::RATE_W-1:0]  linear_speed;
    logic signed [upi_pkg::RATE_W-1:0]  turn_rate;
    logic                               hit_wall;
    logic                               changed;
    logic                               draw_segment;
    logic [upi_pkg::POS_W-1:0]          from_x;
    logic [upi_pkg::POS_W-1:0]          from_y;
  } pose_word_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  longint atan_lut [0:23] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  // Copy of the configuration registers.
  logic [upi_pkg::STEP_W-1:0]        step_time;
  logic [upi_pkg::POS_W-1:0]         canvas_w;
  logic [upi_pkg::POS_W-1:0]         canvas_h;
  logic                              pen_en;
  logic [15:0]                       timeout;
  // Pose and rates; y is kept in screen orientation.
  logic [upi_pkg::POS_W-1:0]         x_pos;
  logic [upi_pkg::POS_W-1:0]         y_screen;
  logic [upi_pkg::ANGLE_W-1:0]       hdg;
  logic signed [upi_pkg::RATE_W-1:0] lin_rate;
  logic signed [upi_pkg::RATE_W-1:0] ang_rate;
  logic [15:0]                       idle_ticks;

  pose_word_t pending_poses [$];
  int fail_count = 0;

  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void sin_cos(input logic [upi_pkg::ANGLE_W-1:0] ang, output longint c,
                                  output longint s);
    logic signed [upi_pkg::ANGLE_W-1:0] hs;
    longint h, x, y, z, dx, dy;
    bit flip;
    hs = ang;
    h = hs;
    flip = 1'b0;
    // Fold into the right half plane, negate the vector afterwards.
    if (h > 16384) begin
      h = h - 32768;
      flip = 1'b1;
    end else if (h < -16384) begin
      h = h + 32768;
      flip = 1'b1;
    end
    x = upi_pkg::CORDIC_GAIN;
    y = 0;
    z = h * 65536;
    for (int i = 0; i < SINCOS_ITERATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [upi_pkg::POS_W-1:0] clamp_pos(input longint v,
                                                          input logic [upi_pkg::POS_W-1:0] hi,
                                                          output bit clipped);
    longint lim;
    lim = hi;
    clipped = 1'b0;
    if (v < 0) begin
      clipped = 1'b1;
      return '0;
    end
    if (v > lim) begin
      clipped = 1'b1;
      return hi;
    end
    return v[upi_pkg::POS_W-1:0];
  endfunction

  function automatic bit move_by(input longint travel);
    longint c, s, px, py;
    bit hx, hy;
    sin_cos(hdg, c, s);
    px = x_pos;
    py = y_screen;
    x_pos = clamp_pos(px + round_shift(c * travel, TRIG_FRAC), canvas_w, hx);
    y_screen = clamp_pos(py - round_shift(s * travel, TRIG_FRAC), canvas_h, hy);
    return hx | hy;
  endfunction

  // Applies one input word to the pose and returns the result word it should give.
  function automatic pose_word_t advance_pose(input logic [upi_pkg::OPCODE_W-1:0] op,
                                              input logic [111:0] d);
    pose_word_t r;
    logic signed [upi_pkg::RATE_W-1:0] lin_f, ang_f;
    logic [upi_pkg::ANGLE_W-1:0] turn, oh;
    logic [upi_pkg::POS_W-1:0] tx, ty, ox, oy;
    longint a, b, dh, travel;
    bit hit, moved;
    lin_f = d[23:0];
    ang_f = d[47:24];
    turn  = d[63:48];
    tx    = d[87:64];
    ty    = d[111:88];
    ox = x_pos;
    oy = y_screen;
    oh = hdg;
    r = '0;
    hit = 1'b0;
    case (op)
      upi_pkg::OP_TICK: begin
        if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks > timeout) begin
          lin_rate = '0;
          ang_rate = '0;
        end
        b = step_time;
        a = ang_rate;
        dh = round_shift(a * b, STEP_FRAC);
        hdg = hdg + dh[upi_pkg::ANGLE_W-1:0];
        a = lin_rate;
        travel = round_shift(a * b, STEP_FRAC);
        hit = move_by(travel);
        moved = (x_pos != ox) || (y_screen != oy);
        r.changed = moved || (hdg != oh);
        r.draw_segment = moved && pen_en;
      end
      upi_pkg::OP_VEL: begin
        lin_rate = lin_f;
        ang_rate = ang_f;
        idle_ticks = '0;
      end
      upi_pkg::OP_REL: begin
        hdg = hdg + turn;
        a = lin_f;
        hit = move_by(a);
        r.changed = 1'b1;
        r.draw_segment = pen_en;
      end
      upi_pkg::OP_ABS: begin
        if (tx > canvas_w) begin
          hit = 1'b1;
          x_pos = canvas_w;
        end else begin
          x_pos = tx;
        end
        // Screen y floors at zero here without counting as a wall hit.
        y_screen = (canvas_h >= ty) ? canvas_h - ty : '0;
        hdg = turn;
        r.changed = 1'b1;
        r.draw_segment = pen_en;
      end
      default: ;
    endcase
    r.pose_x = x_pos;
    r.pose_y = (canvas_h >= y_screen) ? canvas_h - y_screen : '0;
    r.heading = hdg;
    r.linear_speed = lin_rate;
    r.turn_rate = ang_rate;
    r.hit_wall = hit;
    r.from_x = ox;
    r.from_y = oy;
    return r;
  endfunction

  function automatic pose_word_t split_result(input logic [167:0] w);
    pose_word_t r;
    r.pose_x       = w[23:0];
    r.pose_y       = w[47:24];
    r.heading      = w[63:48];
    r.linear_speed = w[87:64];
    r.turn_rate    = w[111:88];
    r.hit_wall     = w[112];
    r.changed      = w[113];
    r.draw_segment = w[114];
    r.from_x       = w[138:115];
    r.from_y       = w[162:139];
    return r;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    pose_word_t want, got, fresh;
    string diffs;
    if (rst) begin
      step_time  = upi_pkg::STEP_TIME_RST;
      canvas_w   = upi_pkg::CANVAS_RST;
      canvas_h   = upi_pkg::CANVAS_RST;
      pen_en     = 1'b1;
      timeout    = upi_pkg::TIMEOUT_RST;
      x_pos      = upi_pkg::CANVAS_RST >> 1;
      y_screen   = upi_pkg::CANVAS_RST >> 1;
      hdg        = '0;
      lin_rate   = '0;
      ang_rate   = '0;
      idle_ticks = '0;
      pending_poses.delete();
      outstanding <= 0;
      mismatches  <= fail_count;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          upi_pkg::REG_STEP_TIME: step_time = cfg_data[upi_pkg::STEP_W-1:0];
          upi_pkg::REG_CANVAS_W:  canvas_w  = cfg_data[upi_pkg::POS_W-1:0];
          upi_pkg::REG_CANVAS_H:  canvas_h  = cfg_data[upi_pkg::POS_W-1:0];
          upi_pkg::REG_PEN_EN:    pen_en    = cfg_data[0];
          upi_pkg::REG_TIMEOUT:   timeout   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = split_result(m_tdata);
        if (pending_poses.size() == 0) begin
          note_fail($sformatf("result word with nothing expected: %h", m_tdata));
        end else begin
          want = pending_poses.pop_front();
          diffs = "";
          if (got.pose_x !== want.pose_x)
            diffs = {diffs, $sformatf(" pose_x %0d/%0d", got.pose_x, want.pose_x)};
          if (got.pose_y !== want.pose_y)
            diffs = {diffs, $sformatf(" pose_y %0d/%0d", got.pose_y, want.pose_y)};
          if (got.heading !== want.heading)
            diffs = {diffs, $sformatf(" heading %0d/%0d", got.heading, want.heading)};
          if (got.linear_speed !== want.linear_speed)
            diffs = {diffs, $sformatf(" linear_speed %0d/%0d", got.linear_speed,
                                      want.linear_speed)};
          if (got.turn_rate !== want.turn_rate)
            diffs = {diffs, $sformatf(" turn_rate %0d/%0d", got.turn_rate, want.turn_rate)};
          if (got.hit_wall !== want.hit_wall)
            diffs = {diffs, $sformatf(" hit_wall %b/%b", got.hit_wall, want.hit_wall)};
          if (got.changed !== want.changed)
            diffs = {diffs, $sformatf(" changed %b/%b", got.changed, want.changed)};
          if (got.draw_segment !== want.draw_segment)
            diffs = {diffs, $sformatf(" draw_segment %b/%b", got.draw_segment,
                                      want.draw_segment)};
          if (got.from_x !== want.from_x)
            diffs = {diffs, $sformatf(" from_x %0d/%0d", got.from_x, want.from_x)};
          if (got.from_y !== want.from_y)
            diffs = {diffs, $sformatf(" from_y %0d/%0d", got.from_y, want.from_y)};
          if (diffs != "") note_fail({"result word differs (actual/expected):", diffs});
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = advance_pose(s_tuser, s_tdata);
        pending_poses = {pending_poses, fresh};
      end
      outstanding <= pending_poses.size();
      mismatches  <= fail_count;
    end
  end

endmodule

@@ verif/tb.sv @@
// Top of the pose integrator testbench: clock, reset, register settings and input
// words with random gaps on both streams. Depends on upi_pkg, the block and pose_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SINCOS_ITER = 16;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [111:0]                   s_tdata;
  logic [upi_pkg::OPCODE_W-1:0]   s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [167:0]                   m_tdata;
  logic                           cfg_wr_en;
  logic [upi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [upi_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             outstanding;
  int                             mismatches;
  logic                           stall_rx;
  logic                           gaps_tx;

  unicycle_pose_integrator #(.SINCOS_ITERATIONS(SINCOS_ITER)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pose_checker #(.SINCOS_ITERATIONS(SINCOS_ITER)) pose_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [23:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rates and distances: mostly within +-span, a quarter anywhere in the field.
  function automatic logic [23:0] pick_rate(input int span);
    int v;
    if ($urandom_range(0, 3) == 0) return rand24();
    v = $urandom_range(0, 2 * span) - span;
    return v[23:0];
  endfunction

  function automatic logic [23:0] pick_target();
    logic [31:0] r;
    if ($urandom_range(0, 1) == 0) return rand24();
    r = $urandom_range(0, 1 << 20);
    return r[23:0];
  endfunction

  function automatic logic [15:0] pick_step();
    logic [31:0] r;
    r = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 65535 : 4096);
    return r[15:0];
  endfunction

  function automatic logic [15:0] pick_timeout();
    logic [31:0] r;
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 30);
    return r[15:0];
  endfunction

  // Responder: ready in random bursts, with stalls while stall_rx is set.
  initial begin
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (stall_rx) begin
        n = idle_span();
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [upi_pkg::OPCODE_W-1:0] op, input logic [111:0] d);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Valid stays high for back-to-back words; it is only lowered for a real gap.
    gap = (gaps_tx && $urandom_range(0, 2) == 0) ? idle_span() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [upi_pkg::OPCODE_W-1:0] op, input logic [23:0] lin,
                          input logic [23:0] ang, input logic [15:0] turn,
                          input logic [23:0] tx, input logic [23:0] ty);
    send_word(op, {ty, tx, turn, ang, lin});
  endtask

  task automatic send_tick();
    send_cmd(upi_pkg::OP_TICK, rand24(), rand24(), rand16(), rand24(), rand24());
  endtask

  // Stop sending and wait until every result word has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] st, input logic [23:0] cw,
                               input logic [23:0] ch, input logic pen,
                               input logic [15:0] tmo);
    cfg_wr_en <= 1'b1;
    cfg_index <= upi_pkg::REG_STEP_TIME;
    cfg_data  <= {8'd0, st};
    @(posedge clk);
    cfg_index <= upi_pkg::REG_CANVAS_W;
    cfg_data  <= cw;
    @(posedge clk);
    cfg_index <= upi_pkg::REG_CANVAS_H;
    cfg_data  <= ch;
    @(posedge clk);
    cfg_index <= upi_pkg::REG_PEN_EN;
    cfg_data  <= {23'd0, pen};
    @(posedge clk);
    cfg_index <= upi_pkg::REG_TIMEOUT;
    cfg_data  <= {8'd0, tmo};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly a velocity command followed by a run of ticks, the rest single words.
  task automatic random_phase(input int n_words);
    int sent, r, k;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 19);
      if (r < 11) begin
        k = $urandom_range(1, 8);
        send_cmd(upi_pkg::OP_VEL, pick_rate(1 << 20), pick_rate(1 << 20), rand16(),
                 rand24(), rand24());
        repeat (k) send_tick();
        sent += k + 1;
      end else if (r < 14) begin
        send_cmd(upi_pkg::OP_REL, pick_rate(1 << 19), rand24(), rand16(), rand24(),
                 rand24());
        sent++;
      end else if (r < 17) begin
        send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), rand16(), pick_target(),
                 pick_target());
        sent++;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    logic [23:0] coin;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= upi_pkg::OP_TICK;
    cfg_wr_en <= 1'b0;
    cfg_index <= upi_pkg::REG_STEP_TIME;
    cfg_data  <= '0;
    stall_rx  <= 1'b1;
    gaps_tx   <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rates at the field extremes, including a heading wrap from a full-scale turn rate.
    send_tick();
    send_cmd(upi_pkg::OP_VEL, 24'h7FFFFF, 24'h000000, rand16(), rand24(), rand24());
    send_tick();
    send_cmd(upi_pkg::OP_VEL, 24'h800000, 24'h800000, rand16(), rand24(), rand24());
    send_tick();
    send_cmd(upi_pkg::OP_VEL, 24'h000000, 24'h7FFFFF, rand16(), rand24(), rand24());
    send_tick();
    // Teleports at the extremes; the first two and the first absolute one run into the walls.
    send_cmd(upi_pkg::OP_REL, 24'h7FFFFF, rand24(), 16'h7FFF, rand24(), rand24());
    send_cmd(upi_pkg::OP_REL, 24'h800000, rand24(), 16'h8000, rand24(), rand24());
    send_cmd(upi_pkg::OP_REL, 24'h000000, rand24(), 16'h0000, rand24(), rand24());
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'h8000, 24'hFFFFFF, 24'hFFFFFF);
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'h7FFF, 24'h000000, 24'h000000);
    // Headings either side of a quarter turn, where the rotator folds the angle.
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'h4000, upi_pkg::CANVAS_RST,
             upi_pkg::CANVAS_RST);
    send_cmd(upi_pkg::OP_REL, 24'd100000, rand24(), 16'h0001, rand24(), rand24());
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'hC000, upi_pkg::CENTRE_RST,
             upi_pkg::CENTRE_RST);
    send_cmd(upi_pkg::OP_REL, 24'd50000, rand24(), 16'h0000, rand24(), rand24());
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'hBFFF, upi_pkg::CENTRE_RST,
             upi_pkg::CENTRE_RST);
    send_cmd(upi_pkg::OP_REL, 24'd50000, rand24(), 16'h0000, rand24(), rand24());
    send_cmd(upi_pkg::OP_ABS, rand24(), rand24(), 16'h0000, 24'd700000, 24'd0);

    // Canvas shrunk under the pose: kept until the next move clamps it.
    settle();
    load_settings(upi_pkg::STEP_TIME_RST, 24'd1000, 24'd1000, 1'b1, upi_pkg::TIMEOUT_RST);
    send_cmd(upi_pkg::OP_VEL, 24'd0, 24'd0, rand16(), rand24(), rand24());
    send_tick();

    // Zero timeout drops the rates on every tick; pen off.
    settle();
    load_settings(upi_pkg::STEP_TIME_RST, upi_pkg::CANVAS_RST, upi_pkg::CANVAS_RST, 1'b0,
                  16'd0);
    send_cmd(upi_pkg::OP_VEL, 24'd1000000, 24'd3000000, rand16(), rand24(), rand24());
    send_tick();
    send_cmd(upi_pkg::OP_REL, 24'd20000, rand24(), 16'h1234, rand24(), rand24());

    for (int p = 0; p < 8; p++) begin
      settle();
      coin = rand24();
      case (p)
        0: load_settings(16'd1, 24'd0, 24'd0, 1'b0, 16'd0);
        1: load_settings(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'hFFFF);
        2: load_settings(upi_pkg::STEP_TIME_RST, upi_pkg::CANVAS_RST, upi_pkg::CANVAS_RST,
                         1'b1, upi_pkg::TIMEOUT_RST);
        default: load_settings(pick_step(), rand24(), rand24(), coin[0], pick_timeout());
      endcase
      stall_rx <= (p % 3 != 1);
      gaps_tx  <= (p % 4 != 2);
      random_phase(103);
    end

    settle();
    // Room for any word the block should not send.
    repeat (SINCOS_ITER + 24) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
